// ===== hdl/deque_with_reverse_macros.svh =====
// ---------------------------------------------------------------------------
// Deque with reverse: assertion macros
// Clocked assertion wrappers shared by the top level and the sequencer.
// ---------------------------------------------------------------------------
`ifndef DEQUE_WITH_REVERSE_MACROS_SVH
`define DEQUE_WITH_REVERSE_MACROS_SVH

// Checked at every rising edge outside reset.
`define DWR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define DWR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/dwr_pkg.sv =====
// ---------------------------------------------------------------------------
// Deque with reverse: package
// Shared constants, operation and status codes, sequencer interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package dwr_pkg;

   localparam int DEPTH_DEFAULT  = 32;
   localparam int VALUE_W        = 32;
   localparam int OP_W           = 3;
   localparam int STATUS_W       = 2;
   localparam int OUT_FIFO_DEPTH = 4;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_REVERSE    = 3'd2,
      OP_READ_FWD   = 3'd3,
      OP_READ_BWD   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Result issued by the sequencer, aligned with the RAM read data.
   typedef struct packed {
      logic       valid;
      logic       from_ram;
      status_type status;
      logic       last;
   } rsp_info_type;

endpackage

`default_nettype wire

// ===== hdl/deque_with_reverse.sv =====
// ---------------------------------------------------------------------------
// Deque with reverse: top level
// Bounded double-ended list of signed 32-bit values in a circular RAM.
// ---------------------------------------------------------------------------
// Operation codes on req_tuser: push front, push back, reverse, read forward,
// read backward; other codes are dropped with no response. Push and reverse
// each return one status transfer. A read returns every stored value in
// order, one transfer per cycle while the output buffer has room, tlast on
// the final one; the single read port of the element RAM sets this pace.
// A read of an empty list returns one transfer with status empty. Reverse
// flips a direction bit of a non-empty list, at a cost independent of fill.
// Results pass through a four-entry output buffer, so input keeps flowing
// while responses wait, until that buffer fills. No init pass after reset.
`default_nettype none
`include "deque_with_reverse_macros.svh"

module deque_with_reverse #(
   parameter int DEPTH = dwr_pkg::DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic signed [dwr_pkg::VALUE_W-1:0]   req_tdata,  // [31:0] value
   input  wire logic        [dwr_pkg::OP_W-1:0]      req_tuser,  // [2:0] operation
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic signed      [dwr_pkg::VALUE_W-1:0]   rsp_tdata,  // [31:0] item_value
   output logic             [dwr_pkg::STATUS_W-1:0]  rsp_tuser,  // [1:0] status
   output logic                                      rsp_tlast
);
   import dwr_pkg::*;

   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FIFO_AW = $clog2(OUT_FIFO_DEPTH);
   localparam int FIFO_CW = $clog2(OUT_FIFO_DEPTH + 1);
   localparam int ENTRY_W = VALUE_W + STATUS_W + 1;

   logic                 ram_wr_en, ram_rd_en;
   logic [AW-1:0]        ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0]   ram_wr_data, ram_rd_data;
   rsp_info_type         issue;
   logic                 can_issue;

   logic [ENTRY_W-1:0]   buf_ff [OUT_FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   cnt_ff, cnt_in;
   logic [FIFO_CW:0]     pending;
   logic                 push, pop;
   logic [VALUE_W-1:0]   push_value;
   logic [ENTRY_W-1:0]   head;

   dwr_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .req_value   (req_tdata),
      .can_issue   (can_issue),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .issue       (issue)
   );

   dwr_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Entries held plus one in flight must leave room for the next issue.
   assign pending    = {1'b0, cnt_ff} + (FIFO_CW+1)'(issue.valid);
   assign can_issue  = pending < (FIFO_CW+1)'(OUT_FIFO_DEPTH);

   assign push       = issue.valid;
   assign pop        = rsp_tvalid && rsp_tready;
   assign push_value = issue.from_ram ? ram_rd_data : '0;
   assign head       = buf_ff[rd_ptr_ff];

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = head[ENTRY_W-1 -: VALUE_W];
   assign rsp_tuser  = head[STATUS_W:1];
   assign rsp_tlast  = head[0];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= {push_value, issue.status, issue.last};
      end
   end

   `DWR_ASSERT(a_buf_no_overflow, !(push && !pop && cnt_ff == FIFO_CW'(OUT_FIFO_DEPTH)), "overflow")
   `DWR_ASSERT(a_ram_data_read, (issue.valid && issue.from_ram) |-> $past(ram_rd_en), "no RAM read")
   `DWR_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_tvalid, "response valid right after reset")

endmodule

`default_nettype wire

// ===== hdl/dwr_ram.sv =====
// ---------------------------------------------------------------------------
// Deque with reverse: generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module dwr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/dwr_seq.sv =====
// ---------------------------------------------------------------------------
// Deque with reverse: sequencer
// Holds window position, count and direction; drives the element RAM and
// steps through the window one entry per cycle on reads while can_issue is high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "deque_with_reverse_macros.svh"

module dwr_seq #(
   parameter int DEPTH = dwr_pkg::DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [dwr_pkg::OP_W-1:0]     req_op,
   input  wire logic [dwr_pkg::VALUE_W-1:0]  req_value,
   input  wire logic                         can_issue,
   output logic                              ram_wr_en,
   output logic [AW-1:0]                     ram_wr_addr,
   output logic [dwr_pkg::VALUE_W-1:0]       ram_wr_data,
   output logic                              ram_rd_en,
   output logic [AW-1:0]                     ram_rd_addr,
   output dwr_pkg::rsp_info_type             issue
);
   import dwr_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          along_ff, along_in;
   rsp_info_type  issue_ff, issue_in;

   op_type        op;
   logic          accept;
   logic [AW-1:0] front_dec;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] pos;
   logic          read_last;

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign op         = op_type'(req_op);
   assign req_tready = (state_ff == ST_IDLE) && can_issue;
   assign accept     = req_tvalid && req_tready;
   assign front_dec  = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - 1'b1;
   assign count_m1   = count_ff - 1'b1;
   assign pos        = along_ff ? idx_ff : count_m1 - idx_ff;
   assign read_last  = (idx_ff == count_m1);
   assign ram_wr_data = req_value;
   assign issue      = issue_ff;

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      rev_in      = rev_ff;
      idx_in      = idx_ff;
      along_in    = along_ff;
      issue_in    = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = front_dec;
      ram_rd_en   = 1'b0;
      ram_rd_addr = slot_of(front_ff, pos[AW-1:0]);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_PUSH_FRONT, OP_PUSH_BACK: begin
                     issue_in.valid = 1'b1;
                     issue_in.last  = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        issue_in.status = STATUS_FULL;
                     end else begin
                        issue_in.status = STATUS_OK;
                        ram_wr_en       = 1'b1;
                        count_in        = count_ff + 1'b1;
                        if ((op == OP_PUSH_FRONT) == !rev_ff) begin
                           front_in    = front_dec;
                           ram_wr_addr = front_dec;
                        end else begin
                           ram_wr_addr = slot_of(front_ff, count_ff[AW-1:0]);
                        end
                     end
                  end
                  OP_REVERSE: begin
                     issue_in.valid  = 1'b1;
                     issue_in.last   = 1'b1;
                     issue_in.status = STATUS_OK;
                     if (count_ff != '0) begin
                        rev_in = !rev_ff;
                     end
                  end
                  OP_READ_FWD, OP_READ_BWD: begin
                     if (count_ff == '0) begin
                        issue_in.valid  = 1'b1;
                        issue_in.last   = 1'b1;
                        issue_in.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_READ;
                        idx_in   = '0;
                        along_in = ((op == OP_READ_FWD) == !rev_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (can_issue) begin
               ram_rd_en         = 1'b1;
               issue_in.valid    = 1'b1;
               issue_in.from_ram = 1'b1;
               issue_in.status   = STATUS_OK;
               issue_in.last     = read_last;
               idx_in            = idx_ff + 1'b1;
               if (read_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         front_ff <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         front_ff <= front_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         issue_ff <= issue_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      along_ff <= along_in;
   end

   `DWR_ASSERT(a_count_bound, count_ff <= CW'(DEPTH), "entry count beyond depth")
   `DWR_ASSERT(a_read_nonempty, (state_ff == ST_READ) |-> (count_ff != '0), "read on empty list")
   `DWR_ASSERT(a_read_end, (state_ff == ST_READ && issue_in.valid && issue_in.last) |=> (state_ff == ST_IDLE), "read did not end after last transfer")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deque with reverse: self-checking testbench
// Drives push, reverse, read and dropped-code requests with bursty input
// and a stalling result side, predicts every result transfer from a local
// copy of the list state and checks each transfer field by field in order.
// ---------------------------------------------------------------------------

module tb_top;
   import dwr_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int HALF_PERIOD    = 6;
   localparam int RANDOM_ITEMS   = 250;
   localparam int HOLD_CYCLES    = 500;
   localparam int HOLD_AT_ITEM   = 120;
   localparam int IDLE_LIMIT     = 4000;
   localparam int TAIL_CYCLES    = 40;
   localparam int MAX_PRINTS     = 40;

   // Codes the block drops without a response.
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
      bit                        drain_first;
   } deque_request_t;

   typedef struct {
      logic signed [VALUE_W-1:0] item_value;
      status_type                status;
      logic                      last;
   } deque_result_t;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic signed [VALUE_W-1:0]   req_tdata = '0;   // [31:0] value
   logic        [OP_W-1:0]      req_tuser = '0;   // [2:0] operation
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic signed [VALUE_W-1:0]   rsp_tdata;        // [31:0] item_value
   logic        [STATUS_W-1:0]  rsp_tuser;        // [1:0] status
   logic                        rsp_tlast;

   deque_request_t pending_requests[$];
   deque_result_t  expected_results[$];

   // Local copy of the list state.
   logic signed [VALUE_W-1:0] deque_slots [DEPTH];
   int  head_slot     = 0;
   int  fill_count    = 0;
   bit  order_flipped = 1'b0;

   int  error_count       = 0;
   int  requests_accepted = 0;
   int  results_seen      = 0;
   int  idle_cycles       = 0;

   int  burst_left = 0;
   int  gap_left   = 0;

   int  stall_mode   = 0;
   int  mode_left    = 0;
   int  stall_phase  = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   deque_with_reverse #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      error_count++;
   endtask

   task automatic add_request(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                              input bit drain_first);
      deque_request_t r;
      r.op          = op;
      r.value       = value;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endtask

   task automatic expect_result(input logic signed [VALUE_W-1:0] item_value,
                                input status_type status, input logic last);
      deque_result_t r;
      r.item_value = item_value;
      r.status     = status;
      r.last       = last;
      expected_results.push_back(r);
   endtask

   // Works out the transfers one accepted request produces and updates the list copy.
   task automatic predict_deque(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
      int  pos;
      bit  along;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill_count >= DEPTH) begin
               expect_result('0, STATUS_FULL, 1'b1);
            end else begin
               // logical front is the physical front unless flipped
               if ((op == OP_PUSH_FRONT) == !order_flipped) begin
                  head_slot = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                  deque_slots[head_slot] = value;
               end else begin
                  deque_slots[(head_slot + fill_count) % DEPTH] = value;
               end
               fill_count++;
               expect_result('0, STATUS_OK, 1'b1);
            end
         end
         OP_REVERSE: begin
            if (fill_count != 0) order_flipped = !order_flipped;
            expect_result('0, STATUS_OK, 1'b1);
         end
         OP_READ_FWD, OP_READ_BWD: begin
            if (fill_count == 0) begin
               expect_result('0, STATUS_EMPTY, 1'b1);
            end else begin
               along = ((op == OP_READ_FWD) == !order_flipped);
               for (int i = 0; i < fill_count; i++) begin
                  pos = along ? i : fill_count - 1 - i;
                  expect_result(deque_slots[(head_slot + pos) % DEPTH], STATUS_OK,
                                (i + 1 == fill_count));
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic logic [OP_W-1:0] random_op();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25)      return OP_PUSH_FRONT;
      else if (pick < 50) return OP_PUSH_BACK;
      else if (pick < 64) return OP_REVERSE;
      else if (pick < 79) return OP_READ_FWD;
      else if (pick < 95) return OP_READ_BWD;
      else                return logic'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)) ?
                                 OP_SPARE_FIRST + 3'($urandom_range(0, 2)) : OP_SPARE_LAST;
   endfunction

   // Sender: bursts of random length, random gaps, optional pause until drained.
   always @(posedge clock) begin
      logic           keep_valid;
      bit             just_taken;
      deque_request_t next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         just_taken = req_tvalid && req_tready;
         keep_valid = req_tvalid && !req_tready;
         if (!keep_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].drain_first &&
                           (just_taken || expected_results.size() != 0))) begin
               next_req   = pending_requests.pop_front();
               req_tuser  <= next_req.op;
               req_tdata  <= next_req.value;
               keep_valid = 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end
         req_tvalid <= keep_valid;
      end
   end

   // Receiver: the stall pattern is redrawn at random, plus one long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && requests_accepted >= HOLD_AT_ITEM) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 80);
         end else begin
            mode_left--;
         end
         stall_phase++;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 4) == 0);
            default: rsp_tready <= (stall_phase % 4 != 3);
         endcase
      end
   end

   // Monitor: predict on request transfers first, then check result transfers.
   always @(posedge clock) begin
      deque_result_t want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_deque(req_tuser, req_tdata);
            requests_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d: transfer with nothing expected",
                                         results_seen));
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata !== want.item_value)
                  report_mismatch($sformatf("result %0d: item_value %h, want %h",
                                            results_seen, rsp_tdata, want.item_value));
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("result %0d: status %0d, want %0d",
                                            results_seen, rsp_tuser, want.status));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("result %0d: last %b, want %b",
                                            results_seen, rsp_tlast, want.last));
            end
            results_seen++;
         end
      end
   end

   // Watchdog on cycles with no transfer on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      int counted;
      logic [OP_W-1:0] op;

      // empty-list cases and dropped codes
      add_request(OP_READ_FWD, $urandom, 1'b0);
      add_request(OP_READ_BWD, $urandom, 1'b0);
      add_request(OP_REVERSE, $urandom, 1'b0);
      add_request(OP_SPARE_FIRST, $urandom, 1'b0);
      add_request(OP_SPARE_FIRST + 3'd1, $urandom, 1'b0);
      add_request(OP_SPARE_LAST, $urandom, 1'b0);
      // value extremes on both ends
      add_request(OP_PUSH_BACK, 32'sh7fff_ffff, 1'b0);
      add_request(OP_PUSH_FRONT, 32'sh8000_0000, 1'b0);
      add_request(OP_PUSH_BACK, 32'sh0000_0000, 1'b0);
      add_request(OP_PUSH_FRONT, -32'sd1, 1'b0);
      add_request(OP_READ_FWD, $urandom, 1'b0);
      add_request(OP_READ_BWD, $urandom, 1'b0);
      add_request(OP_REVERSE, $urandom, 1'b0);
      add_request(OP_READ_FWD, $urandom, 1'b0);
      add_request(OP_PUSH_FRONT, 32'sh5555_5555, 1'b0);
      add_request(OP_PUSH_BACK, 32'shaaaa_aaaa, 1'b0);
      add_request(OP_READ_BWD, $urandom, 1'b0);
      add_request(OP_REVERSE, $urandom, 1'b0);
      add_request(OP_READ_FWD, $urandom, 1'b0);
      add_request(OP_REVERSE, $urandom, 1'b0);

      // Random mix; the list fills up along the way and then sits full.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         op = random_op();
         add_request(op, $urandom, (counted % 60 == 0));
         if (op < OP_SPARE_FIRST) counted++;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

// ===== deque_with_reverse.f =====
+incdir+hdl
hdl/dwr_pkg.sv
hdl/dwr_ram.sv
hdl/dwr_seq.sv
hdl/deque_with_reverse.sv
tb/tb_top.sv
